// ===== hw/rtl/hgl_pkg.sv =====
`timescale 1ns / 1ps

package hgl_pkg;

    // Record kinds on the result channel
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_MOVE  = 2'd1;
    localparam logic [1:0] KIND_DRAW  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Coordinate bias of the font encoding ('R')
    localparam logic [8:0] COORD_BIAS = 9'd82;

    // Empty glyph
    localparam logic [6:0] EMPTY_CHAR  = 7'd32;
    localparam logic [7:0] EMPTY_WIDTH = 8'd16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // One command: raw bytes, the back end does the arithmetic.
    // start: byte_a = right bound, byte_b = left bound
    // move/draw: byte_a = x byte, byte_b = y byte
    // end: steps = step count
    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] char_code;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] steps;
    } t_cmd;

endpackage

// ===== hw/rtl/hgl_front.sv =====
`timescale 1ns / 1ps

module hgl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_line_byte,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output hgl_pkg::t_cmd o_cmd
);

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_BODY   = 2'd1;
    localparam logic [1:0] MODE_DROP   = 2'd2;
    localparam logic [1:0] MODE_EMPTY  = 2'd3;

    localparam logic [3:0] COL_CODE_LAST  = 4'd4;
    localparam logic [3:0] COL_COUNT_LAST = 4'd7;
    localparam logic [3:0] COL_LEFT       = 4'd8;

    typedef struct packed {
        logic [16:0] acc;
        logic        stopped;
        logic        started;
        logic        neg;
        logic        digit;
    } t_num;

    typedef struct packed {
        logic       ok;
        logic [6:0] ch;
    } t_map;

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == 8'd32) || (b == 8'd9) || (b == 8'd11) || (b == 8'd12);
    endfunction

    // one step of a decimal field: blanks, optional sign, digits
    function automatic t_num num_step(input t_num s, input logic [7:0] b);
        t_num r;
        r = s;
        if (!s.stopped) begin
            if (b inside {[8'h30:8'h39]}) begin
                r.acc     = 17'(s.acc * 17'd10 + 17'(b - 8'h30));
                r.started = 1'b1;
                r.digit   = 1'b1;
            end else if (!s.started && is_blank(b)) begin
                r = s;
            end else if (!s.started && (b == 8'h2B || b == 8'h2D)) begin
                r.started = 1'b1;
                r.neg     = (b == 8'h2D);
            end else begin
                r.stopped = 1'b1;
            end
        end
        num_step = r;
    endfunction

    function automatic t_map map_code(input logic [16:0] c);
        t_map m;
        m.ok = 1'b1;
        m.ch = '0;
        if (c >= 17'd501 && c <= 17'd526) begin
            m.ch = 7'(c - 17'd501) + 7'h41;
        end else if (c >= 17'd601 && c <= 17'd626) begin
            m.ch = 7'(c - 17'd601) + 7'h61;
        end else if (c >= 17'd700 && c <= 17'd709) begin
            m.ch = 7'(c - 17'd700) + 7'h30;
        end else begin
            case (c)
                17'd710: m.ch = 7'h2E;
                17'd711: m.ch = 7'h2C;
                17'd712: m.ch = 7'h3A;
                17'd713: m.ch = 7'h3B;
                17'd699: m.ch = 7'h21;
                17'd715: m.ch = 7'h3F;
                default: m.ok = 1'b0;
            endcase
        end
        map_code = m;
    endfunction

    logic [3:0]  r_column,  n_column;
    logic [1:0]  r_mode,    n_mode;
    t_num        r_code,    n_code;
    logic [9:0]  r_count,   n_count;
    logic        r_cnt_stopped, n_cnt_stopped;
    logic        r_cnt_started, n_cnt_started;
    logic        r_cnt_neg, n_cnt_neg;
    logic [6:0]  r_glyph,   n_glyph;
    logic [7:0]  r_left,    n_left;
    logic        r_pen_up,  n_pen_up;
    logic        r_half,    n_half;
    logic [7:0]  r_first,   n_first;
    logic [7:0]  r_steps,   n_steps;

    logic        accept;
    logic        term;
    logic        do_clear;
    t_num        code_nx;
    t_num        cnt_cur;
    t_num        cnt_nx;
    t_map        mapped;

    assign o_ready = i_cmd_ready;
    assign accept  = i_valid && i_cmd_ready;
    assign term    = (i_line_byte == 8'd10) || (i_line_byte == 8'd13) ||
                     (i_line_byte == 8'd0);

    always_comb begin
        cnt_cur = '{acc: {7'd0, r_count}, stopped: r_cnt_stopped,
                    started: r_cnt_started, neg: r_cnt_neg, digit: 1'b0};
        code_nx = num_step(r_code, i_line_byte);
        cnt_nx  = num_step(cnt_cur, i_line_byte);
        mapped  = map_code(code_nx.acc);
    end

    always_comb begin
        n_column      = r_column;
        n_mode        = r_mode;
        n_code        = r_code;
        n_count       = r_count;
        n_cnt_stopped = r_cnt_stopped;
        n_cnt_started = r_cnt_started;
        n_cnt_neg     = r_cnt_neg;
        n_glyph       = r_glyph;
        n_left        = r_left;
        n_pen_up      = r_pen_up;
        n_half        = r_half;
        n_first       = r_first;
        n_steps       = r_steps;
        do_clear      = 1'b0;
        o_cmd_valid   = 1'b0;
        o_cmd         = '0;
        o_cmd.char_code = r_glyph;

        case (r_mode)
            MODE_HEADER: begin
                if (term) begin
                    do_clear = 1'b1;
                end else if (r_column <= COL_CODE_LAST) begin
                    n_code   = code_nx;
                    n_column = r_column + 4'd1;
                    if (r_column == COL_CODE_LAST) begin
                        if (code_nx.digit && !code_nx.neg && mapped.ok) begin
                            n_glyph = mapped.ch;
                        end else begin
                            n_mode = MODE_DROP;
                        end
                    end
                end else if (r_column <= COL_COUNT_LAST) begin
                    n_count       = cnt_nx.acc[9:0];
                    n_cnt_stopped = cnt_nx.stopped;
                    n_cnt_started = cnt_nx.started;
                    n_cnt_neg     = cnt_nx.neg;
                    n_column      = r_column + 4'd1;
                    if (r_column == COL_COUNT_LAST &&
                        (cnt_nx.neg || cnt_nx.acc[9:0] <= 10'd1)) begin
                        // too few vertices: space glyph
                        n_glyph         = hgl_pkg::EMPTY_CHAR;
                        n_mode          = MODE_EMPTY;
                        o_cmd_valid     = 1'b1;
                        o_cmd.kind      = hgl_pkg::KIND_START;
                        o_cmd.char_code = hgl_pkg::EMPTY_CHAR;
                        o_cmd.byte_a    = hgl_pkg::EMPTY_WIDTH;
                        o_cmd.byte_b    = 8'd0;
                    end
                end else if (r_column == COL_LEFT) begin
                    n_left   = i_line_byte;
                    n_column = r_column + 4'd1;
                end else begin
                    n_mode       = MODE_BODY;
                    n_pen_up     = 1'b1;
                    n_half       = 1'b0;
                    n_steps      = 8'd0;
                    o_cmd_valid  = 1'b1;
                    o_cmd.kind   = hgl_pkg::KIND_START;
                    o_cmd.byte_a = i_line_byte;
                    o_cmd.byte_b = r_left;
                end
            end
            MODE_BODY: begin
                if (term) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = hgl_pkg::KIND_END;
                    o_cmd.steps = r_steps;
                    do_clear    = 1'b1;
                end else if (!r_half) begin
                    n_first = i_line_byte;
                    n_half  = 1'b1;
                end else begin
                    n_half = 1'b0;
                    if (r_first == 8'h20 && i_line_byte == 8'h52) begin
                        n_pen_up = 1'b1;    // " R" lifts the pen
                    end else begin
                        o_cmd_valid  = 1'b1;
                        o_cmd.kind   = r_pen_up ? hgl_pkg::KIND_MOVE
                                                : hgl_pkg::KIND_DRAW;
                        o_cmd.byte_a = r_first;
                        o_cmd.byte_b = i_line_byte;
                        n_pen_up     = 1'b0;
                        if (r_steps != 8'hFF) begin
                            n_steps = r_steps + 8'd1;
                        end
                    end
                end
            end
            MODE_EMPTY: begin
                if (term) begin
                    o_cmd_valid     = 1'b1;
                    o_cmd.kind      = hgl_pkg::KIND_END;
                    o_cmd.char_code = hgl_pkg::EMPTY_CHAR;
                    o_cmd.steps     = 8'd0;
                    do_clear        = 1'b1;
                end
            end
            default: begin
                if (term) begin
                    do_clear = 1'b1;
                end
            end
        endcase

        if (do_clear) begin
            n_column      = '0;
            n_mode        = MODE_HEADER;
            n_code        = '0;
            n_count       = '0;
            n_cnt_stopped = 1'b0;
            n_cnt_started = 1'b0;
            n_cnt_neg     = 1'b0;
            n_glyph       = '0;
            n_left        = '0;
            n_pen_up      = 1'b1;
            n_half        = 1'b0;
            n_first       = '0;
            n_steps       = '0;
        end

        // only push on an accepted beat
        o_cmd_valid = o_cmd_valid && accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_mode        <= MODE_HEADER;
            r_code        <= '0;
            r_count       <= '0;
            r_cnt_stopped <= 1'b0;
            r_cnt_started <= 1'b0;
            r_cnt_neg     <= 1'b0;
            r_glyph       <= '0;
            r_left        <= '0;
            r_pen_up      <= 1'b1;
            r_half        <= 1'b0;
            r_first       <= '0;
            r_steps       <= '0;
        end else if (accept) begin
            r_column      <= n_column;
            r_mode        <= n_mode;
            r_code        <= n_code;
            r_count       <= n_count;
            r_cnt_stopped <= n_cnt_stopped;
            r_cnt_started <= n_cnt_started;
            r_cnt_neg     <= n_cnt_neg;
            r_glyph       <= n_glyph;
            r_left        <= n_left;
            r_pen_up      <= n_pen_up;
            r_half        <= n_half;
            r_first       <= n_first;
            r_steps       <= n_steps;
        end
    end

endmodule

// ===== hw/rtl/hgl_queue.sv =====
`timescale 1ns / 1ps

module hgl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hgl_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_pop,
    output hgl_pkg::t_cmd o_cmd
);

    hgl_pkg::t_cmd r_mem [hgl_pkg::QUEUE_DEPTH];

    logic [hgl_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [hgl_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [hgl_pkg::QUEUE_CW-1:0] r_count,  n_count;

    logic do_push;
    logic do_pop;

    assign o_ready = (r_count != hgl_pkg::QUEUE_CW'(hgl_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == hgl_pkg::QUEUE_AW'(hgl_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == hgl_pkg::QUEUE_AW'(hgl_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/hgl_back.sv =====
`timescale 1ns / 1ps

module hgl_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hgl_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_record_kind,
    output logic [6:0]    o_char_code,
    output logic [8:0]    o_glyph_width,
    output logic [8:0]    o_coord_x,
    output logic [8:0]    o_coord_y,
    output logic [7:0]    o_step_total,
    output logic          o_last
);

    logic       r_valid;
    logic [1:0] r_kind;
    logic [6:0] r_char;
    logic [8:0] r_width, n_width;
    logic [8:0] r_x,     n_x;
    logic [8:0] r_y,     n_y;
    logic [7:0] r_steps, n_steps;
    logic       r_last,  n_last;

    assign o_cmd_pop = i_cmd_valid && (!r_valid || i_ready);

    always_comb begin
        n_width = '0;
        n_x     = '0;
        n_y     = '0;
        n_steps = '0;
        n_last  = 1'b0;
        case (i_cmd.kind)
            hgl_pkg::KIND_START: begin
                n_width = {1'b0, i_cmd.byte_a} - {1'b0, i_cmd.byte_b};
            end
            hgl_pkg::KIND_MOVE, hgl_pkg::KIND_DRAW: begin
                n_x = {1'b0, i_cmd.byte_a} - hgl_pkg::COORD_BIAS;
                n_y = hgl_pkg::COORD_BIAS - {1'b0, i_cmd.byte_b};
            end
            hgl_pkg::KIND_END: begin
                n_steps = i_cmd.steps;
                n_last  = 1'b1;
            end
            default: begin
                n_last = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_kind  <= i_cmd.kind;
            r_char  <= i_cmd.char_code;
            r_width <= n_width;
            r_x     <= n_x;
            r_y     <= n_y;
            r_steps <= n_steps;
            r_last  <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_record_kind = r_kind;
    assign o_char_code   = r_char;
    assign o_glyph_width = r_width;
    assign o_coord_x     = r_x;
    assign o_coord_y     = r_y;
    assign o_step_total  = r_steps;
    assign o_last        = r_last;

endmodule

// ===== hw/rtl/hershey_glyph_line_parser.sv =====
// Path: a byte that yields a record is written into the command queue, then into the
//   output register. Throughput: one byte per cycle while the queue has room; the
//   front end updates its parse state on each accepted byte, and the back end drains
//   one record per cycle while i_ready is high or its output register is empty.
// Reset: i_rst_n is synchronous, active low; it clears the line parser to header
//   mode, empties the command queue and drops any pending output record.
`timescale 1ns / 1ps

module hershey_glyph_line_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // byte stream in
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_line_byte,
    // record stream out
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_record_kind,
    output logic [6:0]       o_char_code,
    output logic signed [8:0] o_glyph_width,
    output logic signed [8:0] o_coord_x,
    output logic signed [8:0] o_coord_y,
    output logic [7:0]       o_step_total,
    output logic             o_last
);

    // Front end: tracks column and line mode, parses the glyph code and
    // vertex count, and turns each byte beat into zero or one command.
    // Back end: formats a command into a record (bound difference, coordinate
    // bias) and holds it in the output register until taken.
    // The two-entry queue between them lets the front keep taking bytes while
    // a record waits downstream.

    logic          cmd_push;
    hgl_pkg::t_cmd cmd_in;
    logic          q_ready;
    logic          q_valid;
    logic          q_pop;
    hgl_pkg::t_cmd q_cmd;
    logic [8:0]    width_u;
    logic [8:0]    x_u;
    logic [8:0]    y_u;

    hgl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_line_byte (i_line_byte),
        .o_cmd_valid (cmd_push),
        .i_cmd_ready (q_ready),
        .o_cmd       (cmd_in)
    );

    hgl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    hgl_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (q_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_record_kind (o_record_kind),
        .o_char_code   (o_char_code),
        .o_glyph_width (width_u),
        .o_coord_x     (x_u),
        .o_coord_y     (y_u),
        .o_step_total  (o_step_total),
        .o_last        (o_last)
    );

    // two's complement fields, carried unsigned through the back end
    assign o_glyph_width = signed'(width_u);
    assign o_coord_x     = signed'(x_u);
    assign o_coord_y     = signed'(y_u);

endmodule
